>>> hdl/mm4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared widths, types and codes for the 4x4 Q16.16 matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

    localparam int DIM           = 4;
    localparam int ELEM_W        = 32;
    localparam int IDX_W         = 2;
    localparam int PROD_W        = 2 * ELEM_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int FRAC_BITS_DEF = 16;
    localparam int FIELDS_W      = IDX_W + DIM * ELEM_W;
    localparam int DATA_W        = ((FIELDS_W + 7) / 8) * 8;
    localparam int USER_W        = 1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MUL  = 1'b1
    } t_op;

    typedef logic [ELEM_W-1:0] t_word;
    typedef t_word [DIM-1:0]   t_row;     // [col]
    typedef t_row  [DIM-1:0]   t_mat;     // [row][col]

    typedef logic [PROD_W-1:0]           t_prod;
    typedef t_prod [DIM-1:0][DIM-1:0]    t_prods;   // [k][col]

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] row;
    } t_stage_ctl;

endpackage

>>> hdl/matrix4x4_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// Signed Q16.16 4x4 matrix multiply: load rows of B, stream rows of A through.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata (low bit up)                      tuser
//  s_axis   in   row_index, elem0, elem1, elem2, elem3   operation (0 load, 1 mul)
//  m_axis   out  out_row, prod0, prod1, prod2, prod3     -
//
//  One transfer per cycle on both sides unless m_axis stalls. A multiply row
//  passes through the input register, the product register (sixteen 32x32
//  multipliers) and the result register (column sums, shift, saturate).
//  A load row writes B at the edge it is taken and produces no result; a
//  multiply taken on the next cycle already sees the new row.
//  Reset clears B to zero and empties the pipeline.
//  A stall on m_axis backs up stage by stage; s_axis tready drops only once
//  every stage is full.
//
module matrix4x4_multiply #(
    parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // row_index[1:0], elem0[33:2], elem1[65:34], elem2[97:66], elem3[129:98], zero pad
    input  logic [mm4_pkg::DATA_W-1:0]  i_s_axis_tdata,
    // operation[0]
    input  logic [mm4_pkg::USER_W-1:0]  i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // out_row[1:0], prod0[33:2], prod1[65:34], prod2[97:66], prod3[129:98], zero pad
    output logic [mm4_pkg::DATA_W-1:0]  o_m_axis_tdata
);

    localparam int PAD_W = mm4_pkg::DATA_W - mm4_pkg::FIELDS_W;

    // unpacked input fields
    mm4_pkg::t_op                in_op;
    logic [mm4_pkg::IDX_W-1:0]   in_row;
    mm4_pkg::t_row               in_elems;

    // stage controls
    logic                        s_fire;
    logic                        adv1;
    logic                        adv2;
    logic                        adv3;

    mm4_pkg::t_stage_ctl         r_s1_ctl;
    mm4_pkg::t_row               r_s1_a;
    mm4_pkg::t_stage_ctl         s2_ctl;
    mm4_pkg::t_prods             s2_prods;
    mm4_pkg::t_stage_ctl         s3_ctl;
    mm4_pkg::t_row               s3_row;
    mm4_pkg::t_mat               b_mat;

    always_comb begin
        in_op  = mm4_pkg::t_op'(i_s_axis_tuser[0]);
        in_row = i_s_axis_tdata[mm4_pkg::IDX_W-1:0];
        for (int c = 0; c < mm4_pkg::DIM; c++) begin
            in_elems[c] = i_s_axis_tdata[mm4_pkg::IDX_W + c*mm4_pkg::ELEM_W +: mm4_pkg::ELEM_W];
        end
    end

    // A stage moves when it is empty or the next one moves. The input side
    // follows stage 1, so a load never slips under a multiply still waiting
    // for its products.
    assign adv3            = !s3_ctl.valid || i_m_axis_tready;
    assign adv2            = !s2_ctl.valid || adv3;
    assign adv1            = !r_s1_ctl.valid || adv2;
    assign o_s_axis_tready = adv1;
    assign s_fire          = i_s_axis_tvalid && adv1;

    // input register: multiply rows only
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_ctl.row <= in_row;
            r_s1_a       <= in_elems;
        end
        if (!i_rst_n) begin
            r_s1_ctl.valid <= 1'b0;
        end else if (adv1) begin
            r_s1_ctl.valid <= s_fire && (in_op == mm4_pkg::OP_MUL);
        end
    end

    mm4_bstore u_bstore (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (s_fire && (in_op == mm4_pkg::OP_LOAD)),
        .i_wr_row  (in_row),
        .i_wr_data (in_elems),
        .o_mat     (b_mat)
    );

    mm4_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv2),
        .i_ctl   (r_s1_ctl),
        .i_a     (r_s1_a),
        .i_b     (b_mat),
        .o_ctl   (s2_ctl),
        .o_prods (s2_prods)
    );

    mm4_acc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv3),
        .i_ctl   (s2_ctl),
        .i_prods (s2_prods),
        .o_ctl   (s3_ctl),
        .o_row   (s3_row)
    );

    assign o_m_axis_tvalid = s3_ctl.valid;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, s3_row, s3_ctl.row};

endmodule

>>> hdl/mm4_bstore.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_bstore
// Right-hand matrix B: sixteen words, one row written per load transfer.
// ----------------------------------------------------------------------------
module mm4_bstore (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [mm4_pkg::IDX_W-1:0]  i_wr_row,
    input  mm4_pkg::t_row              i_wr_data,
    output mm4_pkg::t_mat              o_mat
);

    mm4_pkg::t_mat r_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= '0;
        end else if (i_wr_en) begin
            r_mat[i_wr_row] <= i_wr_data;
        end
    end

    assign o_mat = r_mat;

endmodule

>>> hdl/mm4_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_mul
// Product stage: sixteen 32x32 signed products of the A row with B, registered.
// ----------------------------------------------------------------------------
module mm4_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  mm4_pkg::t_stage_ctl i_ctl,
    input  mm4_pkg::t_row       i_a,
    input  mm4_pkg::t_mat       i_b,
    output mm4_pkg::t_stage_ctl o_ctl,
    output mm4_pkg::t_prods     o_prods
);

    mm4_pkg::t_stage_ctl r_ctl;
    mm4_pkg::t_prods     r_prods;
    mm4_pkg::t_prods     n_prods;

    // element k of the A row meets row k of B
    always_comb begin
        logic signed [mm4_pkg::ELEM_W-1:0] a_s;
        logic signed [mm4_pkg::ELEM_W-1:0] b_s;
        logic signed [mm4_pkg::PROD_W-1:0] p_s;
        for (int k = 0; k < mm4_pkg::DIM; k++) begin
            for (int c = 0; c < mm4_pkg::DIM; c++) begin
                a_s = i_a[k];
                b_s = i_b[k][c];
                p_s = a_s * b_s;
                n_prods[k][c] = p_s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl.row <= i_ctl.row;
            r_prods   <= n_prods;
        end
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r_ctl.valid <= i_ctl.valid;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_prods = r_prods;

endmodule

>>> hdl/mm4_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_acc
// Column sums, arithmetic shift by the fraction bits, saturation, result register.
// ----------------------------------------------------------------------------
module mm4_acc #(
    parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  mm4_pkg::t_stage_ctl i_ctl,
    input  mm4_pkg::t_prods     i_prods,
    output mm4_pkg::t_stage_ctl o_ctl,
    output mm4_pkg::t_row       o_row
);

    localparam int EXT_W = mm4_pkg::SUM_W - mm4_pkg::PROD_W;

    mm4_pkg::t_stage_ctl r_ctl;
    mm4_pkg::t_row       r_row;
    mm4_pkg::t_row       n_row;

    always_comb begin
        logic signed [mm4_pkg::SUM_W-1:0] sum;
        logic signed [mm4_pkg::SUM_W-1:0] shd;
        for (int c = 0; c < mm4_pkg::DIM; c++) begin
            sum = '0;
            for (int k = 0; k < mm4_pkg::DIM; k++) begin
                sum = sum + {{EXT_W{i_prods[k][c][mm4_pkg::PROD_W-1]}}, i_prods[k][c]};
            end
            shd = sum >>> FRAC_BITS;
            // in range when every bit above the result's sign agrees with it
            if (&shd[mm4_pkg::SUM_W-1:mm4_pkg::ELEM_W-1]
                    || ~|shd[mm4_pkg::SUM_W-1:mm4_pkg::ELEM_W-1]) begin
                n_row[c] = shd[mm4_pkg::ELEM_W-1:0];
            end else if (shd[mm4_pkg::SUM_W-1]) begin
                n_row[c] = {1'b1, {(mm4_pkg::ELEM_W-1){1'b0}}};
            end else begin
                n_row[c] = {1'b0, {(mm4_pkg::ELEM_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl.row <= i_ctl.row;
            r_row     <= n_row;
        end
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r_ctl.valid <= i_ctl.valid;
        end
    end

    assign o_ctl = r_ctl;
    assign o_row = r_row;

endmodule

>>> tb/sv/matrix4x4_multiply_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4x4_multiply_tb
// Self-checking bench for the Q16.16 4x4 matrix multiplier.
// Rows of B and A stream in over s_axis. A local copy of B and a fixed-point
// row product predict each m_axis transfer, which is checked field by field.
// Both sides idle at random, and the sink holds off once for a long time.
// ----------------------------------------------------------------------------
module matrix4x4_multiply_tb;

    localparam int FRAC     = mm4_pkg::FRAC_BITS_DEF;
    localparam int N_ITEMS  = 850;
    localparam int HOLD_LEN = 64;     // long sink hold-off, in cycles
    localparam int MAX_SHOW = 10;
    localparam int DIM      = mm4_pkg::DIM;
    localparam int IDX_W    = mm4_pkg::IDX_W;
    localparam int ELEM_W   = mm4_pkg::ELEM_W;
    localparam int PROD_W   = mm4_pkg::PROD_W;
    localparam int SUM_W    = mm4_pkg::SUM_W;
    localparam int FIELDS_W = mm4_pkg::FIELDS_W;
    localparam int DATA_W   = mm4_pkg::DATA_W;
    localparam int USER_W   = mm4_pkg::USER_W;

    // one s_axis transfer
    typedef struct {
        mm4_pkg::t_op     op;
        logic [IDX_W-1:0] row;
        mm4_pkg::t_row    elems;
    } t_row_item;

    // one m_axis transfer
    typedef struct {
        logic [IDX_W-1:0] row;
        mm4_pkg::t_row    prods;
    } t_product;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    // row_index[1:0], elem0..elem3 at [33:2]..[129:98], zero pad
    logic [DATA_W-1:0]   i_s_axis_tdata = '0;
    // operation[0]
    logic [USER_W-1:0]   i_s_axis_tuser = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    // out_row[1:0], prod0..prod3 at [33:2]..[129:98], zero pad
    logic [DATA_W-1:0]   o_m_axis_tdata;

    // stimulus and scoreboard
    t_row_item     pending_rows[$];
    t_product      expected_products[$];
    t_row_item     offered_row;
    logic          in_taken = 1'b0;
    mm4_pkg::t_mat b_matrix = '0;        // bench copy of the stored B

    // idling
    int        tx_gap = 0;
    int        rx_gap = 0;
    logic      tx_quiet = 1'b0;
    logic      rx_quiet = 1'b0;
    logic      rx_hold = 1'b0;

    // statistics
    int        n_errors = 0;
    int        n_loads = 0;
    int        n_muls = 0;
    int        n_results = 0;
    int        n_saturated = 0;
    int        n_in_stall = 0;

    matrix4x4_multiply #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Row product in Q16.16: exact sum of four 64-bit products, arithmetic
    // shift (floor), saturate to 32 bits.
    // ------------------------------------------------------------------------
    function automatic mm4_pkg::t_word dot_column(mm4_pkg::t_row a, int col);
        logic signed [SUM_W+1:0]  acc;
        logic signed [PROD_W-1:0] p;
        logic signed [SUM_W+1:0]  sat_hi;
        logic signed [SUM_W+1:0]  sat_lo;
        sat_hi = 2147483647;
        sat_lo = -sat_hi - 1;
        acc = '0;
        for (int k = 0; k < DIM; k++) begin
            p   = $signed(a[k]) * $signed(b_matrix[k][col]);
            acc = acc + p;
        end
        acc = acc >>> FRAC;
        if (acc > sat_hi) begin
            n_saturated++;
            return 32'h7FFF_FFFF;
        end
        if (acc < sat_lo) begin
            n_saturated++;
            return 32'h8000_0000;
        end
        return acc[ELEM_W-1:0];
    endfunction

    // Applies one accepted row: a load updates B, a multiply queues its product.
    function automatic void apply_row(t_row_item it);
        t_product pr;
        if (it.op == mm4_pkg::OP_LOAD) begin
            b_matrix[it.row] = it.elems;
            n_loads++;
        end else begin
            pr.row = it.row;
            for (int c = 0; c < DIM; c++)
                pr.prods[c] = dot_column(it.elems, c);
            expected_products.push_back(pr);
            n_muls++;
        end
    endfunction

    // mostly short gaps, a few long ones, none in quiet stretches
    function automatic int pick_gap(logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic mm4_pkg::t_word rand_elem();
        mm4_pkg::t_word v;
        case ($urandom_range(0, 9))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2, 3, 4: begin
                // small Q16.16 values, up to +/-4.0
                v = $urandom_range(0, 32'h0004_0000);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic mm4_pkg::t_row rand_row();
        mm4_pkg::t_row r;
        for (int c = 0; c < DIM; c++)
            r[c] = rand_elem();
        return r;
    endfunction

    function automatic void add_row(mm4_pkg::t_op op, int row, mm4_pkg::t_row elems);
        t_row_item it;
        it.op    = op;
        it.row   = row[IDX_W-1:0];
        it.elems = elems;
        pending_rows.push_back(it);
    endfunction

    // ------------------------------------------------------------------------
    // Input side: acceptance is sampled at the rising edge, the driver moves
    // on at the falling edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready)
                apply_row(offered_row);
            if (i_s_axis_tvalid && !o_s_axis_tready)
                n_in_stall++;
        end
    end

    always @(negedge i_clk) begin : row_driver
        t_row_item it;
        if ($urandom_range(0, 299) == 0)
            tx_quiet <= !tx_quiet;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap          <= tx_gap - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_rows.size() > 0) begin
                it              = pending_rows.pop_front();
                offered_row     <= it;
                i_s_axis_tdata  <= {{(DATA_W - FIELDS_W){1'b0}}, it.elems, it.row};
                i_s_axis_tuser  <= it.op;
                i_s_axis_tvalid <= 1'b1;
                tx_gap          <= pick_gap(tx_quiet);
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: random stalls, plus one long hold-off so the pipeline
    // backs up and tready on the input side drops.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if ($urandom_range(0, 299) == 0)
            rx_quiet <= !rx_quiet;
        if (!i_rst_n || rx_hold) begin
            i_m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap          <= rx_gap - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rx_gap <= pick_gap(rx_quiet);
        end
    end

    initial begin
        wait (n_results >= 150);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    task automatic note_mismatch(string what, mm4_pkg::t_word want, mm4_pkg::t_word got);
        if (n_errors < MAX_SHOW)
            $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        n_errors++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_product         want;
        logic [IDX_W-1:0] got_row;
        mm4_pkg::t_row    got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_row = o_m_axis_tdata[IDX_W-1:0];
            got     = o_m_axis_tdata[FIELDS_W-1:IDX_W];
            n_results <= n_results + 1;
            if (expected_products.size() == 0) begin
                if (n_errors < MAX_SHOW)
                    $display("[%0t] result with no multiply pending: row %0d",
                             $realtime, got_row);
                n_errors++;
            end else begin
                want = expected_products.pop_front();
                if (got_row != want.row)
                    note_mismatch("out_row", 32'(want.row), 32'(got_row));
                for (int c = 0; c < DIM; c++)
                    if (got[c] != want.prods[c])
                        note_mismatch($sformatf("prod%0d", c), want.prods[c], got[c]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int start;
        int step;

        // B still at reset: every product is zero
        add_row(mm4_pkg::OP_MUL, 0,
                {32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF});
        // identity B passes extremes through
        for (int r = 0; r < DIM; r++) begin
            mm4_pkg::t_row e;
            e    = '0;
            e[r] = 32'h0001_0000;
            add_row(mm4_pkg::OP_LOAD, r, e);
        end
        add_row(mm4_pkg::OP_MUL, 1,
                {32'hFFFF_0000, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        // B all max positive: positive and negative overflow
        for (int r = 0; r < DIM; r++)
            add_row(mm4_pkg::OP_LOAD, r, {DIM{32'h7FFF_FFFF}});
        add_row(mm4_pkg::OP_MUL, 2, {DIM{32'h7FFF_FFFF}});
        add_row(mm4_pkg::OP_MUL, 3, {DIM{32'h8000_0000}});
        add_row(mm4_pkg::OP_MUL, 0, {32'h0, 32'h0, 32'h0, 32'h0000_0001});
        // B all most negative: the largest sum, 2^64, saturates high
        for (int r = 0; r < DIM; r++)
            add_row(mm4_pkg::OP_LOAD, r, {DIM{32'h8000_0000}});
        add_row(mm4_pkg::OP_MUL, 3, {DIM{32'h8000_0000}});
        // floor rounding: -1 * raw 1 shifts to -1, +1 * raw 1 to 0
        add_row(mm4_pkg::OP_LOAD, 0, {DIM{32'h0000_0001}});
        add_row(mm4_pkg::OP_LOAD, 1, '0);
        add_row(mm4_pkg::OP_MUL, 1, {32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF});
        add_row(mm4_pkg::OP_MUL, 2, {32'h0, 32'h0, 32'h0, 32'h0000_0001});

        // random: mostly a full B load followed by a burst of A rows,
        // the rest lone loads and multiplies
        while (pending_rows.size() < N_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    start = $urandom_range(0, 3);
                    step  = $urandom_range(0, 1) ? 1 : 3;
                    for (int i = 0; i < DIM; i++)
                        add_row(mm4_pkg::OP_LOAD, (start + i * step) % DIM, rand_row());
                    repeat ($urandom_range(2, 8))
                        add_row(mm4_pkg::OP_MUL, $urandom_range(0, 3), rand_row());
                end
                6, 7:    add_row(mm4_pkg::OP_LOAD, $urandom_range(0, 3), rand_row());
                default: add_row(mm4_pkg::OP_MUL, $urandom_range(0, 3), rand_row());
            endcase
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_rows.size() > 0 || i_s_axis_tvalid || expected_products.size() > 0)
            @(posedge i_clk);
        // drain: three pipeline stages plus margin for a stray output
        repeat (12) @(posedge i_clk);

        $display("Covered %0d B row loads and %0d A row multiplies, %0d results checked.",
                 n_loads, n_muls, n_results);
        $display("Saturated elements: %0d; cycles with input held off: %0d; errors: %0d.",
                 n_saturated, n_in_stall, n_errors);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Run timed out");
        $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/mm4_pkg.sv
hdl/mm4_bstore.sv
hdl/mm4_mul.sv
hdl/mm4_acc.sv
hdl/matrix4x4_multiply.sv
tb/sv/matrix4x4_multiply_tb.sv
